/* rtl/sphere_vertex_generator_top_defines.svh */
// Shared assertion macros for the sphere vertex generator.
`ifndef SPHERE_VERTEX_GENERATOR_TOP_DEFINES_SVH
`define SPHERE_VERTEX_GENERATOR_TOP_DEFINES_SVH

// The condition on the right must hold in the same cycle as the one on the left.
`define SVG_ASSERT_SAME(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error(msg);

// The condition on the right must hold in the cycle after the one on the left.
`define SVG_ASSERT_NEXT(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

/* rtl/svg_pkg.sv */
package svg_pkg;

   localparam int SVG_ANGLE_BITS = 12;
   localparam int SVG_FRAC_BITS  = 14;
   localparam int SVG_MAX_DIV    = 1024;

   localparam int SVG_QUARTER    = 1 << (SVG_ANGLE_BITS - 2);
   localparam int SVG_ADDR_W     = SVG_ANGLE_BITS - 1;
   localparam int SVG_MAG_W      = SVG_FRAC_BITS + 1;
   localparam int SVG_UNIT_W     = SVG_FRAC_BITS + 2;

   localparam int SVG_RING_W     = 10;
   localparam int SVG_SEG_W      = 11;
   localparam int SVG_DIV_W      = 11;
   localparam int SVG_HALF_W     = SVG_DIV_W - 1;
   localparam int SVG_QUO_W      =
      ((SVG_ANGLE_BITS > SVG_FRAC_BITS) ? SVG_ANGLE_BITS : SVG_FRAC_BITS) + 1;
   localparam int SVG_NUM_W      = SVG_DIV_W + SVG_QUO_W;

   localparam int SVG_COMP_W     = 23;
   localparam int SVG_SCALE_W    = 16;
   localparam int SVG_SCALE_FRAC = 8;
   localparam int SVG_KIND_W     = 3;
   localparam int SVG_CSR_W      = 16;
   localparam int SVG_CSR_IDX_W  = 2;

   localparam logic [63:0] SVG_HALF_PI_Q30 = 64'd1686629713;

   localparam logic [SVG_KIND_W-1:0] KIND_POS    = 3'd0;
   localparam logic [SVG_KIND_W-1:0] KIND_TEX    = 3'd1;
   localparam logic [SVG_KIND_W-1:0] KIND_TAN    = 3'd2;
   localparam logic [SVG_KIND_W-1:0] KIND_BITAN  = 3'd3;
   localparam logic [SVG_KIND_W-1:0] KIND_NORMAL = 3'd4;
   localparam logic [SVG_KIND_W-1:0] KIND_ERR    = 3'd5;

   localparam logic [SVG_CSR_IDX_W-1:0] CSR_DIVISIONS = 2'd0;
   localparam logic [SVG_CSR_IDX_W-1:0] CSR_SCALE_X   = 2'd1;
   localparam logic [SVG_CSR_IDX_W-1:0] CSR_SCALE_Y   = 2'd2;
   localparam logic [SVG_CSR_IDX_W-1:0] CSR_SCALE_Z   = 2'd3;

   localparam int LANE_PA = 0;
   localparam int LANE_PB = 1;
   localparam int LANE_U  = 2;
   localparam int LANE_V  = 3;

   typedef struct packed {
      logic [SVG_DIV_W-1:0] rem;
      logic [SVG_QUO_W-1:0] num;
      logic [SVG_QUO_W-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic                  err;
      div_lane_type [3:0]    lane;
   } div_item_type;

   typedef struct packed {
      logic                         err;
      logic signed [SVG_COMP_W-1:0] pos_x;
      logic signed [SVG_COMP_W-1:0] pos_y;
      logic signed [SVG_COMP_W-1:0] pos_z;
      logic [SVG_QUO_W-1:0]         u;
      logic [SVG_QUO_W-1:0]         v;
      logic signed [SVG_UNIT_W-1:0] nx;
      logic signed [SVG_UNIT_W-1:0] ny;
      logic signed [SVG_UNIT_W-1:0] c;
      logic signed [SVG_UNIT_W-1:0] tx;
      logic signed [SVG_UNIT_W-1:0] bx;
      logic signed [SVG_UNIT_W-1:0] by;
      logic signed [SVG_UNIT_W-1:0] nsb;
   } vtx_type;

   typedef logic [SVG_MAG_W-1:0] sine_rom_type [0:SVG_QUARTER];

   // Quarter-wave sine in Q30 by a Taylor series, rounded to the unit format.
   function automatic sine_rom_type sine_rom_build();
      sine_rom_type       rom;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        prod;
      logic signed [63:0] sum;
      for (int k = 0; k < SVG_QUARTER; k++) begin
         x = (64'(k) * SVG_HALF_PI_Q30 + 64'(SVG_QUARTER / 2)) / SVG_QUARTER;
         x2 = (x * x + (64'd1 << 29)) >> 30;
         term = x;
         sum = $signed(x);
         for (int n = 1; n <= 8; n++) begin
            prod = (term * x2 + (64'd1 << 29)) >> 30;
            case (n)
               1: term = prod / 64'd6;
               2: term = prod / 64'd20;
               3: term = prod / 64'd42;
               4: term = prod / 64'd72;
               5: term = prod / 64'd110;
               6: term = prod / 64'd156;
               7: term = prod / 64'd210;
               default: term = prod / 64'd272;
            endcase
            if ((n & 1) == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = '0;
         end
         rom[k] = SVG_MAG_W'(($unsigned(sum) + (64'd1 << (29 - SVG_FRAC_BITS)))
                             >> (30 - SVG_FRAC_BITS));
      end
      rom[0] = '0;
      rom[SVG_QUARTER] = SVG_MAG_W'(1 << SVG_FRAC_BITS);
      return rom;
   endfunction

endpackage

/* rtl/svg_div.sv */
module svg_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_stall,
   input  logic [svg_pkg::SVG_RING_W-1:0]  ring,
   input  logic [svg_pkg::SVG_SEG_W-1:0]   segment,
   input  logic [svg_pkg::SVG_DIV_W-1:0]   den,
   input  logic [svg_pkg::SVG_HALF_W-1:0]  half,
   output logic                            out_valid,
   input  logic                            out_stall,
   output svg_pkg::div_item_type           out_item
);

   logic [svg_pkg::SVG_QUO_W:0]   valid_ff;
   logic [svg_pkg::SVG_QUO_W+1:0] stall;
   svg_pkg::div_item_type         item_ff [0:svg_pkg::SVG_QUO_W];
   svg_pkg::div_item_type         entry_in;
   logic [svg_pkg::SVG_NUM_W-1:0] num_pa;
   logic [svg_pkg::SVG_NUM_W-1:0] num_pb;
   logic [svg_pkg::SVG_NUM_W-1:0] num_u;
   logic [svg_pkg::SVG_NUM_W-1:0] num_v;

   function automatic svg_pkg::div_lane_type lane_init(
      input logic [svg_pkg::SVG_NUM_W-1:0] num
   );
      svg_pkg::div_lane_type l;
      l.rem = num[svg_pkg::SVG_NUM_W-1:svg_pkg::SVG_QUO_W];
      l.num = num[svg_pkg::SVG_QUO_W-1:0];
      l.quo = '0;
      return l;
   endfunction

   function automatic svg_pkg::div_lane_type lane_step(
      input svg_pkg::div_lane_type       l,
      input logic [svg_pkg::SVG_DIV_W-1:0] d
   );
      svg_pkg::div_lane_type       r;
      logic [svg_pkg::SVG_DIV_W:0] t;
      logic                        ge;
      t = {l.rem, l.num[svg_pkg::SVG_QUO_W-1]};
      ge = (t >= {1'b0, d});
      r.rem = ge ? svg_pkg::SVG_DIV_W'(t - {1'b0, d}) : t[svg_pkg::SVG_DIV_W-1:0];
      r.num = {l.num[svg_pkg::SVG_QUO_W-2:0], 1'b0};
      r.quo = {l.quo[svg_pkg::SVG_QUO_W-2:0], ge};
      return r;
   endfunction

   function automatic svg_pkg::div_item_type item_step(
      input svg_pkg::div_item_type          it,
      input logic [svg_pkg::SVG_DIV_W-1:0]  d,
      input logic [svg_pkg::SVG_HALF_W-1:0] h
   );
      svg_pkg::div_item_type r;
      r.err = it.err;
      r.lane[svg_pkg::LANE_PA] = lane_step(it.lane[svg_pkg::LANE_PA], d);
      r.lane[svg_pkg::LANE_PB] = lane_step(it.lane[svg_pkg::LANE_PB], d);
      r.lane[svg_pkg::LANE_U]  = lane_step(it.lane[svg_pkg::LANE_U], d);
      r.lane[svg_pkg::LANE_V]  = lane_step(it.lane[svg_pkg::LANE_V], {1'b0, h});
      return r;
   endfunction

   always_comb begin
      num_pa = (svg_pkg::SVG_NUM_W'(ring) << svg_pkg::SVG_ANGLE_BITS)
               + svg_pkg::SVG_NUM_W'(den >> 1);
      num_pb = (svg_pkg::SVG_NUM_W'(segment) << svg_pkg::SVG_ANGLE_BITS)
               + svg_pkg::SVG_NUM_W'(den >> 1);
      num_u  = (svg_pkg::SVG_NUM_W'(segment) << svg_pkg::SVG_FRAC_BITS)
               + svg_pkg::SVG_NUM_W'(den >> 1);
      num_v  = (svg_pkg::SVG_NUM_W'(ring) << svg_pkg::SVG_FRAC_BITS)
               + svg_pkg::SVG_NUM_W'(half >> 1);
      entry_in.err = (den == '0) || ({1'b0, ring} > half)
                     || (segment > den);
      entry_in.lane[svg_pkg::LANE_PA] = lane_init(num_pa);
      entry_in.lane[svg_pkg::LANE_PB] = lane_init(num_pb);
      entry_in.lane[svg_pkg::LANE_U]  = lane_init(num_u);
      entry_in.lane[svg_pkg::LANE_V]  = lane_init(num_v);
   end

   always_comb begin
      stall[svg_pkg::SVG_QUO_W+1] = out_stall;
      for (int k = svg_pkg::SVG_QUO_W; k >= 0; k--) begin
         stall[k] = valid_ff[k] && stall[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (!stall[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k <= svg_pkg::SVG_QUO_W; k++) begin
            if (!stall[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!stall[0]) begin
         item_ff[0] <= entry_in;
      end
      for (int k = 1; k <= svg_pkg::SVG_QUO_W; k++) begin
         if (!stall[k]) begin
            item_ff[k] <= item_step(item_ff[k-1], den, half);
         end
      end
   end

   assign in_stall  = stall[0];
   assign out_valid = valid_ff[svg_pkg::SVG_QUO_W];
   assign out_item  = item_ff[svg_pkg::SVG_QUO_W];

endmodule

/* rtl/svg_trig.sv */
module svg_trig (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_stall,
   input  svg_pkg::div_item_type                 in_item,
   input  logic                                  half_zero,
   input  logic signed [svg_pkg::SVG_SCALE_W-1:0] scale_x,
   input  logic signed [svg_pkg::SVG_SCALE_W-1:0] scale_y,
   input  logic signed [svg_pkg::SVG_SCALE_W-1:0] scale_z,
   output logic                                  out_valid,
   input  logic                                  out_stall,
   output svg_pkg::vtx_type                      out_item
);

   localparam svg_pkg::sine_rom_type SINE_ROM_A = svg_pkg::sine_rom_build();
   localparam svg_pkg::sine_rom_type SINE_ROM_B = svg_pkg::sine_rom_build();

   typedef struct packed {
      logic [svg_pkg::SVG_ADDR_W-1:0] addr;
      logic                           neg;
   } loc_type;

   typedef struct packed {
      logic                           err;
      logic [svg_pkg::SVG_MAG_W-1:0]  s_mag;
      logic [svg_pkg::SVG_MAG_W-1:0]  c_mag;
      logic [svg_pkg::SVG_MAG_W-1:0]  sb_mag;
      logic [svg_pkg::SVG_MAG_W-1:0]  cb_mag;
      logic                           s_neg;
      logic                           c_neg;
      logic                           sb_neg;
      logic                           cb_neg;
      logic [svg_pkg::SVG_QUO_W-1:0]  u;
      logic [svg_pkg::SVG_QUO_W-1:0]  v;
   } look_type;

   typedef struct packed {
      logic                                 err;
      logic signed [svg_pkg::SVG_UNIT_W-1:0] s;
      logic signed [svg_pkg::SVG_UNIT_W-1:0] c;
      logic signed [svg_pkg::SVG_UNIT_W-1:0] sb;
      logic signed [svg_pkg::SVG_UNIT_W-1:0] cb;
      logic signed [svg_pkg::SVG_UNIT_W-1:0] nsb;
      logic [svg_pkg::SVG_QUO_W-1:0]        u;
      logic [svg_pkg::SVG_QUO_W-1:0]        v;
   } trig_type;

   typedef struct packed {
      logic                                 err;
      logic signed [svg_pkg::SVG_UNIT_W-1:0] nx;
      logic signed [svg_pkg::SVG_UNIT_W-1:0] ny;
      logic signed [svg_pkg::SVG_UNIT_W-1:0] tx;
      logic signed [svg_pkg::SVG_UNIT_W-1:0] bx;
      logic signed [svg_pkg::SVG_UNIT_W-1:0] by;
      logic signed [svg_pkg::SVG_UNIT_W-1:0] c;
      logic signed [svg_pkg::SVG_UNIT_W-1:0] nsb;
      logic [svg_pkg::SVG_QUO_W-1:0]        u;
      logic [svg_pkg::SVG_QUO_W-1:0]        v;
   } prod_type;

   logic [3:0]  valid_ff;
   logic [4:0]  stall;
   look_type    look_ff;
   trig_type    trig_ff;
   prod_type    prod_ff;
   svg_pkg::vtx_type vtx_ff;
   logic [svg_pkg::SVG_ANGLE_BITS-1:0] pa;
   logic [svg_pkg::SVG_ANGLE_BITS-1:0] pb;
   loc_type     s_loc;
   loc_type     c_loc;
   loc_type     sb_loc;
   loc_type     cb_loc;

   function automatic loc_type sine_loc(input logic [svg_pkg::SVG_ANGLE_BITS-1:0] p);
      loc_type                          r;
      logic [svg_pkg::SVG_ANGLE_BITS-3:0] off;
      off = p[svg_pkg::SVG_ANGLE_BITS-3:0];
      r.addr = p[svg_pkg::SVG_ANGLE_BITS-2]
               ? svg_pkg::SVG_ADDR_W'(svg_pkg::SVG_QUARTER) - {1'b0, off}
               : {1'b0, off};
      r.neg = p[svg_pkg::SVG_ANGLE_BITS-1];
      return r;
   endfunction

   function automatic logic signed [svg_pkg::SVG_UNIT_W-1:0] signed_unit(
      input logic [svg_pkg::SVG_MAG_W-1:0] mag,
      input logic                          neg
   );
      logic signed [svg_pkg::SVG_UNIT_W-1:0] m;
      m = $signed({1'b0, mag});
      return neg ? -m : m;
   endfunction

   function automatic logic signed [svg_pkg::SVG_UNIT_W-1:0] umul(
      input logic signed [svg_pkg::SVG_UNIT_W-1:0] a,
      input logic signed [svg_pkg::SVG_UNIT_W-1:0] b
   );
      logic signed [2*svg_pkg::SVG_UNIT_W-1:0] prod;
      logic signed [2*svg_pkg::SVG_UNIT_W-1:0] rnd;
      prod = a * b;
      rnd = prod + (2*svg_pkg::SVG_UNIT_W)'(1 << (svg_pkg::SVG_FRAC_BITS - 1));
      return rnd[svg_pkg::SVG_FRAC_BITS +: svg_pkg::SVG_UNIT_W];
   endfunction

   function automatic logic signed [svg_pkg::SVG_COMP_W-1:0] scl(
      input logic signed [svg_pkg::SVG_UNIT_W-1:0]  a,
      input logic signed [svg_pkg::SVG_SCALE_W-1:0] s
   );
      logic signed [svg_pkg::SVG_UNIT_W+svg_pkg::SVG_SCALE_W-1:0] prod;
      logic signed [svg_pkg::SVG_UNIT_W+svg_pkg::SVG_SCALE_W-1:0] rnd;
      prod = a * s;
      rnd = prod + (svg_pkg::SVG_UNIT_W + svg_pkg::SVG_SCALE_W)'(
                1 << (svg_pkg::SVG_SCALE_FRAC - 1));
      return rnd[svg_pkg::SVG_SCALE_FRAC +: svg_pkg::SVG_COMP_W];
   endfunction

   always_comb begin
      pa = in_item.lane[svg_pkg::LANE_PA].quo[svg_pkg::SVG_ANGLE_BITS-1:0];
      pb = in_item.lane[svg_pkg::LANE_PB].quo[svg_pkg::SVG_ANGLE_BITS-1:0];
      s_loc  = sine_loc(pa);
      c_loc  = sine_loc(pa + svg_pkg::SVG_ANGLE_BITS'(svg_pkg::SVG_QUARTER));
      sb_loc = sine_loc(pb);
      cb_loc = sine_loc(pb + svg_pkg::SVG_ANGLE_BITS'(svg_pkg::SVG_QUARTER));
   end

   always_comb begin
      stall[4] = out_stall;
      for (int k = 3; k >= 0; k--) begin
         stall[k] = valid_ff[k] && stall[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (!stall[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < 4; k++) begin
            if (!stall[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!stall[0]) begin
         look_ff.err    <= in_item.err;
         look_ff.s_mag  <= SINE_ROM_A[s_loc.addr];
         look_ff.c_mag  <= SINE_ROM_A[c_loc.addr];
         look_ff.sb_mag <= SINE_ROM_B[sb_loc.addr];
         look_ff.cb_mag <= SINE_ROM_B[cb_loc.addr];
         look_ff.s_neg  <= s_loc.neg;
         look_ff.c_neg  <= c_loc.neg;
         look_ff.sb_neg <= sb_loc.neg;
         look_ff.cb_neg <= cb_loc.neg;
         look_ff.u      <= in_item.lane[svg_pkg::LANE_U].quo;
         look_ff.v      <= half_zero ? '0 : in_item.lane[svg_pkg::LANE_V].quo;
      end
      if (!stall[1]) begin
         trig_ff.err <= look_ff.err;
         trig_ff.s   <= signed_unit(look_ff.s_mag, look_ff.s_neg);
         trig_ff.c   <= signed_unit(look_ff.c_mag, look_ff.c_neg);
         trig_ff.sb  <= signed_unit(look_ff.sb_mag, look_ff.sb_neg);
         trig_ff.cb  <= signed_unit(look_ff.cb_mag, look_ff.cb_neg);
         trig_ff.nsb <= signed_unit(look_ff.sb_mag, !look_ff.sb_neg);
         trig_ff.u   <= look_ff.u;
         trig_ff.v   <= look_ff.v;
      end
      if (!stall[2]) begin
         prod_ff.err <= trig_ff.err;
         prod_ff.nx  <= umul(trig_ff.cb, trig_ff.s);
         prod_ff.ny  <= umul(trig_ff.sb, trig_ff.s);
         prod_ff.tx  <= umul(trig_ff.nsb, trig_ff.s);
         prod_ff.bx  <= umul(trig_ff.cb, trig_ff.cb);
         prod_ff.by  <= umul(trig_ff.sb, trig_ff.cb);
         prod_ff.c   <= trig_ff.c;
         prod_ff.nsb <= trig_ff.nsb;
         prod_ff.u   <= trig_ff.u;
         prod_ff.v   <= trig_ff.v;
      end
      if (!stall[3]) begin
         vtx_ff.err   <= prod_ff.err;
         vtx_ff.pos_x <= scl(prod_ff.nx, scale_x);
         vtx_ff.pos_y <= scl(prod_ff.ny, scale_y);
         vtx_ff.pos_z <= scl(prod_ff.c, scale_z);
         vtx_ff.u     <= prod_ff.u;
         vtx_ff.v     <= prod_ff.v;
         vtx_ff.nx    <= prod_ff.nx;
         vtx_ff.ny    <= prod_ff.ny;
         vtx_ff.c     <= prod_ff.c;
         vtx_ff.tx    <= prod_ff.tx;
         vtx_ff.bx    <= prod_ff.bx;
         vtx_ff.by    <= prod_ff.by;
         vtx_ff.nsb   <= prod_ff.nsb;
      end
   end

   assign in_stall  = stall[0];
   assign out_valid = valid_ff[3];
   assign out_item  = vtx_ff;

endmodule

/* rtl/svg_emit.sv */
module svg_emit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_stall,
   input  svg_pkg::vtx_type                       in_item,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [svg_pkg::SVG_KIND_W-1:0]         rsp_kind,
   output logic signed [svg_pkg::SVG_COMP_W-1:0]  rsp_comp_x,
   output logic signed [svg_pkg::SVG_COMP_W-1:0]  rsp_comp_y,
   output logic signed [svg_pkg::SVG_COMP_W-1:0]  rsp_comp_z,
   output logic                                   rsp_last
);

   svg_pkg::vtx_type              item_ff;
   logic                          valid_ff;
   logic [svg_pkg::SVG_KIND_W-1:0] beat_ff;
   logic                          last_beat;
   logic                          take;
   logic                          load;

   assign last_beat = (beat_ff == svg_pkg::KIND_NORMAL) || (beat_ff == svg_pkg::KIND_ERR);
   assign take      = valid_ff && !rsp_stall;
   assign load      = !valid_ff || (take && last_beat);
   assign in_stall  = !load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= svg_pkg::KIND_POS;
      end else if (load) begin
         valid_ff <= in_valid;
         if (in_valid) begin
            beat_ff <= in_item.err ? svg_pkg::KIND_ERR : svg_pkg::KIND_POS;
         end
      end else if (take) begin
         beat_ff <= beat_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         item_ff <= in_item;
      end
   end

   always_comb begin
      case (beat_ff)
         svg_pkg::KIND_POS: begin
            rsp_comp_x = item_ff.pos_x;
            rsp_comp_y = item_ff.pos_y;
            rsp_comp_z = item_ff.pos_z;
         end
         svg_pkg::KIND_TEX: begin
            rsp_comp_x = svg_pkg::SVG_COMP_W'(item_ff.u);
            rsp_comp_y = svg_pkg::SVG_COMP_W'(item_ff.v);
            rsp_comp_z = '0;
         end
         svg_pkg::KIND_TAN: begin
            rsp_comp_x = svg_pkg::SVG_COMP_W'(item_ff.tx);
            rsp_comp_y = svg_pkg::SVG_COMP_W'(item_ff.nx);
            rsp_comp_z = svg_pkg::SVG_COMP_W'(item_ff.c);
         end
         svg_pkg::KIND_BITAN: begin
            rsp_comp_x = svg_pkg::SVG_COMP_W'(item_ff.bx);
            rsp_comp_y = svg_pkg::SVG_COMP_W'(item_ff.by);
            rsp_comp_z = svg_pkg::SVG_COMP_W'(item_ff.nsb);
         end
         svg_pkg::KIND_NORMAL: begin
            rsp_comp_x = svg_pkg::SVG_COMP_W'(item_ff.nx);
            rsp_comp_y = svg_pkg::SVG_COMP_W'(item_ff.ny);
            rsp_comp_z = svg_pkg::SVG_COMP_W'(item_ff.c);
         end
         default: begin
            rsp_comp_x = '0;
            rsp_comp_y = '0;
            rsp_comp_z = '0;
         end
      endcase
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind  = beat_ff;
   assign rsp_last  = last_beat;

endmodule

/* rtl/sphere_vertex_generator_top.sv */
// Sphere vertex generator.
// The request channel takes one grid point (req_ring, req_segment) per beat, qualified
// by req_valid and held back by req_stall. For each valid grid point the response
// channel gives five beats in order: position, texture coordinate, tangent, bitangent
// and normal, with rsp_last on the normal. A grid point outside the grid, or any point
// while divisions is zero, gives one error beat with zero components and rsp_last set.
// The configuration port writes divisions and the three scale factors on any cycle
// with csr_write high; write it only while no grid point is in flight.
// The first beat of a grid point passes through one entry stage, a 15-stage
// restoring divider that yields the phases and the texture coordinates one quotient
// bit per stage, four trig stages and the response register.
// A new grid point may enter every cycle while req_stall is low; the sustained rate
// is set by the response channel, at five beats per grid point and one per error.
// A stall on the response channel holds the current beat and backs up the pipeline
// stage by stage, so req_stall rises only once every stage is full.
// Synchronous reset empties the pipeline and sets divisions to 16 and each scale
// factor to 1.0.
module sphere_vertex_generator_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [svg_pkg::SVG_RING_W-1:0]         req_ring,
   input  logic [svg_pkg::SVG_SEG_W-1:0]          req_segment,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [svg_pkg::SVG_KIND_W-1:0]         rsp_kind,
   output logic signed [svg_pkg::SVG_COMP_W-1:0]  rsp_comp_x,
   output logic signed [svg_pkg::SVG_COMP_W-1:0]  rsp_comp_y,
   output logic signed [svg_pkg::SVG_COMP_W-1:0]  rsp_comp_z,
   output logic                                   rsp_last,
   input  logic                                   csr_write,
   input  logic [svg_pkg::SVG_CSR_IDX_W-1:0]      csr_index,
   input  logic [svg_pkg::SVG_CSR_W-1:0]          csr_data
);

   logic [svg_pkg::SVG_DIV_W-1:0]          divisions_ff;
   logic signed [svg_pkg::SVG_SCALE_W-1:0] scale_x_ff;
   logic signed [svg_pkg::SVG_SCALE_W-1:0] scale_y_ff;
   logic signed [svg_pkg::SVG_SCALE_W-1:0] scale_z_ff;
   logic [svg_pkg::SVG_DIV_W-1:0]          den;
   logic [svg_pkg::SVG_HALF_W-1:0]         half;
   logic                                   div_valid;
   logic                                   div_stall;
   svg_pkg::div_item_type                  div_item;
   logic                                   vtx_valid;
   logic                                   vtx_stall;
   svg_pkg::vtx_type                       vtx_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         divisions_ff <= svg_pkg::SVG_DIV_W'(16);
         scale_x_ff   <= svg_pkg::SVG_SCALE_W'(256);
         scale_y_ff   <= svg_pkg::SVG_SCALE_W'(256);
         scale_z_ff   <= svg_pkg::SVG_SCALE_W'(256);
      end else if (csr_write) begin
         case (csr_index)
            svg_pkg::CSR_DIVISIONS: divisions_ff <= csr_data[svg_pkg::SVG_DIV_W-1:0];
            svg_pkg::CSR_SCALE_X:   scale_x_ff   <= csr_data;
            svg_pkg::CSR_SCALE_Y:   scale_y_ff   <= csr_data;
            svg_pkg::CSR_SCALE_Z:   scale_z_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign den  = (divisions_ff > svg_pkg::SVG_DIV_W'(svg_pkg::SVG_MAX_DIV))
                 ? svg_pkg::SVG_DIV_W'(svg_pkg::SVG_MAX_DIV) : divisions_ff;
   assign half = den[svg_pkg::SVG_DIV_W-1:1];

   svg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .ring      (req_ring),
      .segment   (req_segment),
      .den       (den),
      .half      (half),
      .out_valid (div_valid),
      .out_stall (div_stall),
      .out_item  (div_item)
   );

   svg_trig u_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_stall  (div_stall),
      .in_item   (div_item),
      .half_zero (half == '0),
      .scale_x   (scale_x_ff),
      .scale_y   (scale_y_ff),
      .scale_z   (scale_z_ff),
      .out_valid (vtx_valid),
      .out_stall (vtx_stall),
      .out_item  (vtx_item)
   );

   svg_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (vtx_valid),
      .in_stall   (vtx_stall),
      .in_item    (vtx_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_kind   (rsp_kind),
      .rsp_comp_x (rsp_comp_x),
      .rsp_comp_y (rsp_comp_y),
      .rsp_comp_z (rsp_comp_z),
      .rsp_last   (rsp_last)
   );

endmodule

/* rtl/svg_checker.sv */
`include "sphere_vertex_generator_top_defines.svh"

module svg_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [svg_pkg::SVG_KIND_W-1:0]         rsp_kind,
   input logic signed [svg_pkg::SVG_COMP_W-1:0]  rsp_comp_x,
   input logic signed [svg_pkg::SVG_COMP_W-1:0]  rsp_comp_y,
   input logic signed [svg_pkg::SVG_COMP_W-1:0]  rsp_comp_z,
   input logic                                   rsp_last
);

   // A stalled response beat keeps its kind and components.
   `SVG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_comp_x) && $stable(rsp_comp_y)
      && $stable(rsp_comp_z), "stalled response beat changed")

   // Beats of one grid point follow each other in kind order without a gap.
   `SVG_ASSERT_NEXT(a_beat_order, rsp_valid && !rsp_stall && !rsp_last,
      rsp_valid && (rsp_kind == $past(rsp_kind) + 3'd1), "response beats out of order")

   // The last flag marks exactly the normal beat and the error beat.
   `SVG_ASSERT_SAME(a_last_kind, rsp_valid,
      rsp_last == ((rsp_kind == svg_pkg::KIND_NORMAL) || (rsp_kind == svg_pkg::KIND_ERR)),
      "last flag on wrong beat")

   // An error beat carries zero components.
   `SVG_ASSERT_SAME(a_err_zero, rsp_valid && (rsp_kind == svg_pkg::KIND_ERR),
      (rsp_comp_x == '0) && (rsp_comp_y == '0) && (rsp_comp_z == '0),
      "error beat with nonzero data")

endmodule

bind sphere_vertex_generator_top svg_checker u_svg_checker (.*);

/* sim/tb_sphere_vertex_generator_top.sv */
module tb_sphere_vertex_generator_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD = 300;

   typedef struct {
      logic [svg_pkg::SVG_RING_W-1:0] ring;
      logic [svg_pkg::SVG_SEG_W-1:0]  seg;
   } grid_point_type;

   typedef struct {
      logic [svg_pkg::SVG_KIND_W-1:0] kind;
      logic [svg_pkg::SVG_COMP_W-1:0] x;
      logic [svg_pkg::SVG_COMP_W-1:0] y;
      logic [svg_pkg::SVG_COMP_W-1:0] z;
      logic                           last;
   } vertex_beat_type;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_stall;
   logic [svg_pkg::SVG_RING_W-1:0]         req_ring;
   logic [svg_pkg::SVG_SEG_W-1:0]          req_segment;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic [svg_pkg::SVG_KIND_W-1:0]         rsp_kind;
   logic signed [svg_pkg::SVG_COMP_W-1:0]  rsp_comp_x;
   logic signed [svg_pkg::SVG_COMP_W-1:0]  rsp_comp_y;
   logic signed [svg_pkg::SVG_COMP_W-1:0]  rsp_comp_z;
   logic                                   rsp_last;
   logic                                   csr_write;
   logic [svg_pkg::SVG_CSR_IDX_W-1:0]      csr_index;
   logic [svg_pkg::SVG_CSR_W-1:0]          csr_data;

   grid_point_type  pending_points[$];
   vertex_beat_type expected_beats[$];
   longint          sine_q14[0:svg_pkg::SVG_QUARTER];
   logic [svg_pkg::SVG_DIV_W-1:0]          divisions_q;
   logic signed [svg_pkg::SVG_SCALE_W-1:0] scale_x_q;
   logic signed [svg_pkg::SVG_SCALE_W-1:0] scale_y_q;
   logic signed [svg_pkg::SVG_SCALE_W-1:0] scale_z_q;
   int  error_count = 0;
   int  cycle_count = 0;
   int  req_gap = 0;
   int  stall_gap = 0;
   int  hold_left = 0;
   bit  req_took = 0;
   bit  quiet = 0;
   bit  hold_go = 0;
   bit  hold_done = 0;

   sphere_vertex_generator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_ring(req_ring), .req_segment(req_segment),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind), .rsp_comp_x(rsp_comp_x), .rsp_comp_y(rsp_comp_y),
      .rsp_comp_z(rsp_comp_z), .rsp_last(rsp_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic void build_sine_table();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      for (int k = 0; k < svg_pkg::SVG_QUARTER; k++) begin
         x = (longint'(k) * 64'd1686629713 + svg_pkg::SVG_QUARTER / 2)
             / svg_pkg::SVG_QUARTER;
         x2 = (x * x + (64'd1 << 29)) >> 30;
         term = x;
         sum = longint'(x);
         for (int n = 1; n <= 8; n++) begin
            term = ((term * x2 + (64'd1 << 29)) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         sine_q14[k] = (sum + (longint'(1) << (29 - svg_pkg::SVG_FRAC_BITS)))
                       >>> (30 - svg_pkg::SVG_FRAC_BITS);
      end
      sine_q14[0] = 0;
      sine_q14[svg_pkg::SVG_QUARTER] = longint'(1) << svg_pkg::SVG_FRAC_BITS;
   endfunction

   function automatic longint sine_at(int unsigned p);
      int unsigned quadrant;
      int unsigned offset;
      quadrant = (p % (1 << svg_pkg::SVG_ANGLE_BITS)) / svg_pkg::SVG_QUARTER;
      offset = p % svg_pkg::SVG_QUARTER;
      case (quadrant)
         0: return sine_q14[offset];
         1: return sine_q14[svg_pkg::SVG_QUARTER - offset];
         2: return -sine_q14[offset];
         default: return -sine_q14[svg_pkg::SVG_QUARTER - offset];
      endcase
   endfunction

   function automatic longint cosine_at(int unsigned p);
      return sine_at(p + svg_pkg::SVG_QUARTER);
   endfunction

   function automatic int unsigned phase_of_index(int unsigned idx, int unsigned d);
      return 32'(((longint'(idx) << svg_pkg::SVG_ANGLE_BITS) + d / 2) / d
                 % (1 << svg_pkg::SVG_ANGLE_BITS));
   endfunction

   function automatic longint unit_mul(longint a, longint b);
      return (a * b + (longint'(1) << (svg_pkg::SVG_FRAC_BITS - 1)))
             >>> svg_pkg::SVG_FRAC_BITS;
   endfunction

   function automatic longint scale_mul(longint u,
                                        logic signed [svg_pkg::SVG_SCALE_W-1:0] s);
      return (u * longint'(s) + 128) >>> svg_pkg::SVG_SCALE_FRAC;
   endfunction

   function automatic logic [svg_pkg::SVG_COMP_W-1:0] clamp_comp(longint v);
      if (v > 4194303) begin
         v = 4194303;
      end
      if (v < -4194304) begin
         v = -4194304;
      end
      return v[svg_pkg::SVG_COMP_W-1:0];
   endfunction

   function automatic vertex_beat_type make_beat(logic [svg_pkg::SVG_KIND_W-1:0] kind,
                                                 longint x, longint y, longint z,
                                                 logic last);
      vertex_beat_type b;
      b.kind = kind;
      b.x = clamp_comp(x);
      b.y = clamp_comp(y);
      b.z = clamp_comp(z);
      b.last = last;
      return b;
   endfunction

   task automatic expect_beat(vertex_beat_type b);
      expected_beats.insert(expected_beats.size(), b);
   endtask

   task automatic predict_vertex(grid_point_type g);
      int unsigned d;
      int unsigned half;
      int unsigned pa;
      int unsigned pb;
      longint c, s, cb, sb, nx, ny, u, v;
      d = (divisions_q > svg_pkg::SVG_MAX_DIV) ? svg_pkg::SVG_MAX_DIV : divisions_q;
      half = d / 2;
      if (d == 0 || g.ring > half || g.seg > d) begin
         expect_beat(make_beat(svg_pkg::KIND_ERR, 0, 0, 0, 1'b1));
      end else begin
         pa = phase_of_index(g.ring, d);
         pb = phase_of_index(g.seg, d);
         c = cosine_at(pa);
         s = sine_at(pa);
         cb = cosine_at(pb);
         sb = sine_at(pb);
         nx = unit_mul(cb, s);
         ny = unit_mul(sb, s);
         u = ((longint'(g.seg) << svg_pkg::SVG_FRAC_BITS) + d / 2) / d;
         v = (half != 0) ? ((longint'(g.ring) << svg_pkg::SVG_FRAC_BITS) + half / 2) / half
                         : 0;
         expect_beat(make_beat(svg_pkg::KIND_POS, scale_mul(nx, scale_x_q),
            scale_mul(ny, scale_y_q), scale_mul(c, scale_z_q), 1'b0));
         expect_beat(make_beat(svg_pkg::KIND_TEX, u, v, 0, 1'b0));
         expect_beat(make_beat(svg_pkg::KIND_TAN,
            unit_mul(cosine_at(pb + svg_pkg::SVG_QUARTER), s),
            unit_mul(sine_at(pb + svg_pkg::SVG_QUARTER), s), c, 1'b0));
         expect_beat(make_beat(svg_pkg::KIND_BITAN, unit_mul(cb, cb), unit_mul(sb, cb),
            cosine_at(pb + svg_pkg::SVG_QUARTER), 1'b0));
         expect_beat(make_beat(svg_pkg::KIND_NORMAL, nx, ny, c, 1'b1));
      end
   endtask

   task automatic report_mismatch(string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Request side: accept, predict, and drive the next point at the falling edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_vertex(pending_points[0]);
         void'(pending_points.pop_front());
         req_took = 1;
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_took)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_points.size() > 0) begin
            req_valid <= 1'b1;
            req_ring <= pending_points[0].ring;
            req_segment <= pending_points[0].seg;
            if (!quiet && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(1, 11);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_took = 0;
   end

   // Response side: random stall bursts plus one long hold-off.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_go && !hold_done) begin
         hold_done = 1;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (stall_gap > 0) begin
         stall_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_gap = $urandom_range(1, 11);
         end
      end
   end

   always @(posedge clock) begin
      vertex_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d", rsp_kind));
         end else begin
            want = expected_beats.pop_front();
            if (rsp_kind !== want.kind) begin
               report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
            end
            if (rsp_comp_x !== want.x) begin
               report_mismatch($sformatf("kind %0d comp_x %h, want %h", want.kind,
                  rsp_comp_x, want.x));
            end
            if (rsp_comp_y !== want.y) begin
               report_mismatch($sformatf("kind %0d comp_y %h, want %h", want.kind,
                  rsp_comp_y, want.y));
            end
            if (rsp_comp_z !== want.z) begin
               report_mismatch($sformatf("kind %0d comp_z %h, want %h", want.kind,
                  rsp_comp_z, want.z));
            end
            if (rsp_last !== want.last) begin
               report_mismatch($sformatf("kind %0d last %0d, want %0d", want.kind,
                  rsp_last, want.last));
            end
         end
      end
   end

   task automatic write_reg(logic [svg_pkg::SVG_CSR_IDX_W-1:0] idx,
                            logic [svg_pkg::SVG_CSR_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         svg_pkg::CSR_DIVISIONS: divisions_q = value[svg_pkg::SVG_DIV_W-1:0];
         svg_pkg::CSR_SCALE_X: scale_x_q = value;
         svg_pkg::CSR_SCALE_Y: scale_y_q = value;
         default: scale_z_q = value;
      endcase
   endtask

   task automatic configure(int divs, int sx, int sy, int sz);
      write_reg(svg_pkg::CSR_DIVISIONS, svg_pkg::SVG_CSR_W'(divs));
      write_reg(svg_pkg::CSR_SCALE_X, svg_pkg::SVG_CSR_W'(sx));
      write_reg(svg_pkg::CSR_SCALE_Y, svg_pkg::SVG_CSR_W'(sy));
      write_reg(svg_pkg::CSR_SCALE_Z, svg_pkg::SVG_CSR_W'(sz));
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic add_point(int ring, int seg);
      grid_point_type g;
      g.ring = svg_pkg::SVG_RING_W'(ring);
      g.seg = svg_pkg::SVG_SEG_W'(seg);
      pending_points.insert(pending_points.size(), g);
   endtask

   task automatic drain();
      while (pending_points.size() > 0 || expected_beats.size() > 0) begin
         @(posedge clock);
      end
      repeat (30) @(posedge clock);
   endtask

   task automatic add_random_points(int count);
      int d;
      for (int i = 0; i < count; i++) begin
         d = (divisions_q > svg_pkg::SVG_MAX_DIV) ? svg_pkg::SVG_MAX_DIV : divisions_q;
         if (d == 0 || $urandom_range(0, 6) == 0) begin
            add_point($urandom_range(0, 1023), $urandom_range(0, 2047));
         end else begin
            add_point($urandom_range(0, d / 2), $urandom_range(0, d));
         end
      end
   endtask

   initial begin
      int divs;
      reset = 1'b1;
      req_valid = 1'b0;
      req_ring = '0;
      req_segment = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = svg_pkg::CSR_DIVISIONS;
      csr_data = '0;
      divisions_q = 16;
      scale_x_q = 256;
      scale_y_q = 256;
      scale_z_q = 256;
      build_sine_table();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: poles, equator, seam, and out-of-range points.
      add_point(0, 0);
      add_point(8, 16);
      add_point(4, 4);
      add_point(4, 12);
      add_point(2, 3);
      add_point(5, 15);
      add_point(9, 0);
      add_point(0, 17);
      add_point(1023, 2047);
      add_point(1, 1);
      drain();

      // One division: no rings, so v is zero.
      configure(1, 16'h8000, 16'h7fff, 16'h0000);
      add_point(0, 0);
      add_point(0, 1);
      add_point(1, 0);
      add_point(0, 2);
      drain();

      // Zero divisions: every point is an error.
      configure(0, 256, 256, 256);
      add_point(0, 0);
      add_point(1, 1);
      drain();

      configure(1024, 16'h7fff, 16'h7fff, 16'h8000);
      add_point(512, 1024);
      add_point(511, 1023);
      add_point(256, 512);
      add_point(513, 0);
      add_point(0, 1025);
      drain();

      // Above the maximum, divisions saturate.
      configure(2047, 16'h8000, 16'h8000, 16'h7fff);
      add_point(512, 1024);
      add_point(512, 1025);
      add_point(300, 777);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 5))
            0: divs = $urandom_range(0, 2047);
            1: divs = 1024;
            default: divs = $urandom_range(1, 40);
         endcase
         configure(divs, $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
         if (phase == 2) begin
            hold_go = 1;
         end
         if (phase == 7) begin
            quiet = 1;
         end
         add_random_points(25);
         drain();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

/* sim.f */
+incdir+rtl
rtl/svg_pkg.sv
rtl/svg_div.sv
rtl/svg_trig.sv
rtl/svg_emit.sv
rtl/sphere_vertex_generator_top.sv
rtl/svg_checker.sv
sim/tb_sphere_vertex_generator_top.sv
